// ===== sv/mrm_pkg.sv =====
// shared types and constants for the modrm/sib operand decoder
package mrm_pkg;

    // register set codes
    localparam logic [1:0] REG_SET_8  = 2'd0;
    localparam logic [1:0] REG_SET_16 = 2'd1;
    localparam logic [1:0] REG_SET_32 = 2'd2;

    // modrm mod field codes
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISPF   = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    // special rm / sib codes
    localparam logic [2:0] RM_SIB      = 3'd4;
    localparam logic [2:0] RM_DISP     = 3'd5;
    localparam logic [2:0] SIB_NO_IDX  = 3'd4;
    localparam logic [2:0] SIB_NO_BASE = 3'd5;

    typedef struct packed {
        logic        is_memory;
        logic        has_base;
        logic        has_index;
        logic        has_disp;
        logic [1:0]  register_set;
        logic [2:0]  base_register;
        logic [2:0]  index_register;
        logic [3:0]  scale_factor;
        logic [31:0] displacement;
        logic [2:0]  operand_length;
    } t_operand;

endpackage

// ===== sv/x86_modrm_sib_operand_decode.sv =====
// top level: two-stage pipelined modrm/sib/displacement operand decoder
// Decodes one ModRM byte, an optional SIB byte and the displacement that
// follows into an operand description, one beat per cycle while the output
// is not stalled. A beat taken on the input channel is held in an input
// register, decoded by a single level of combinational logic and captured
// into the result register, which drives the output channel. The input
// stalls only when both registers are full and the output is stalled.
// protected_mode (reset 1) selects 32-bit full displacements; when 0 a full
// displacement is 16 bits, zero-extended. The config write channel is always
// ready and must be written only while the block is idle.
module x86_modrm_sib_operand_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_opcode,
    input  logic               i_opsize_override,
    input  logic [7:0]         i_modrm_byte,
    input  logic [39:0]        i_following_bytes,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_is_memory,
    output logic               o_has_base,
    output logic               o_has_index,
    output logic               o_has_disp,
    output logic [1:0]         o_register_set,
    output logic [2:0]         o_base_register,
    output logic [2:0]         o_index_register,
    output logic [3:0]         o_scale_factor,
    output logic signed [31:0] o_displacement,
    output logic [2:0]         o_operand_length
);

    logic                r_pm;
    logic                r_s1_valid;
    logic                r_full;
    logic                r_osz;
    logic [7:0]          r_modrm;
    logic [39:0]         r_fb;
    logic                r_out_valid;
    mrm_pkg::t_operand   r_res;
    mrm_pkg::t_operand   n_res;

    logic s2_free;
    logic s1_free;

    assign s2_free    = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pm <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s1_free && i_in_valid) begin
            r_full  <= i_opcode;
            r_osz   <= i_opsize_override;
            r_modrm <= i_modrm_byte;
            r_fb    <= i_following_bytes;
        end
        if (s2_free && r_s1_valid) begin
            r_res <= n_res;
        end
    end

    // decode
    logic [1:0]  mod_f;
    logic [2:0]  rm_f;
    logic        sib;
    logic [7:0]  sib_byte;
    logic [7:0]  d8;
    logic [31:0] dfull;
    logic        mem_base;

    always_comb begin
        mod_f    = r_modrm[7:6];
        rm_f     = r_modrm[2:0];
        sib      = (rm_f == mrm_pkg::RM_SIB);
        sib_byte = r_fb[7:0];
        d8       = sib ? r_fb[15:8] : r_fb[7:0];
        dfull    = sib ? r_fb[39:8] : r_fb[31:0];
        if (!r_pm) begin
            dfull[31:16] = 16'd0;
        end
        if (sib) begin
            mem_base = !(mod_f == mrm_pkg::MOD_NO_DISP && sib_byte[2:0] == mrm_pkg::SIB_NO_BASE);
        end else begin
            mem_base = !(mod_f == mrm_pkg::MOD_NO_DISP && rm_f == mrm_pkg::RM_DISP);
        end

        n_res = '0;
        n_res.scale_factor   = 4'd1;
        n_res.operand_length = 3'd1;
        if (mod_f == mrm_pkg::MOD_REG) begin
            n_res.base_register = rm_f;
            if (!r_full) begin
                n_res.register_set = mrm_pkg::REG_SET_8;
            end else if (r_osz) begin
                n_res.register_set = mrm_pkg::REG_SET_16;
            end else begin
                n_res.register_set = mrm_pkg::REG_SET_32;
            end
        end else begin
            n_res.is_memory = 1'b1;
            n_res.has_base  = mem_base;
            if (mem_base) begin
                n_res.base_register = sib ? sib_byte[2:0] : rm_f;
            end
            if (sib) begin
                n_res.operand_length = 3'd2;
                if (sib_byte[5:3] != mrm_pkg::SIB_NO_IDX) begin
                    n_res.has_index      = 1'b1;
                    n_res.index_register = sib_byte[5:3];
                    n_res.scale_factor   = 4'd1 << sib_byte[7:6];
                end
            end
            if (mod_f == mrm_pkg::MOD_DISP8) begin
                n_res.has_disp       = 1'b1;
                n_res.displacement   = {{24{d8[7]}}, d8};
                n_res.operand_length = n_res.operand_length + 3'd1;
            end else if (mod_f == mrm_pkg::MOD_DISPF || !mem_base) begin
                n_res.has_disp       = 1'b1;
                n_res.displacement   = dfull;
                n_res.operand_length = n_res.operand_length + (r_pm ? 3'd4 : 3'd2);
            end
            if (mod_f == mrm_pkg::MOD_NO_DISP && !sib) begin
                n_res.register_set = r_pm ? mrm_pkg::REG_SET_32 : mrm_pkg::REG_SET_16;
            end else begin
                n_res.register_set = mrm_pkg::REG_SET_32;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_memory      = r_res.is_memory;
    assign o_has_base       = r_res.has_base;
    assign o_has_index      = r_res.has_index;
    assign o_has_disp       = r_res.has_disp;
    assign o_register_set   = r_res.register_set;
    assign o_base_register  = r_res.base_register;
    assign o_index_register = r_res.index_register;
    assign o_scale_factor   = r_res.scale_factor;
    assign o_displacement   = r_res.displacement;
    assign o_operand_length = r_res.operand_length;

    // register form never carries address parts
    a_reg_form_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_memory) |-> (!o_has_base && !o_has_index && !o_has_disp))
        else $error("register form with address flags");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_operand_length >= 3'd1 && o_operand_length <= 3'd6))
        else $error("operand length out of range");

    a_no_index_defaults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_index) |-> (o_scale_factor == 4'd1 && o_index_register == 3'd0))
        else $error("unused index fields not cleared");

    // input only stalls when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && o_out_valid && i_out_stall))
        else $error("input stalled without a full pipe");

    // a stage holding a beat under output stall keeps its result
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_displacement)
            && $stable(o_operand_length)))
        else $error("result changed under stall");

endmodule
